// ----- src/pll_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pll_pkg
// Shared constants for the piecewise-linear lookup core: default sizes,
// stream field layout, status codes and register map.
// ----------------------------------------------------------------------------
package pll_pkg;

    // default sizing
    localparam int MAX_POINTS_DEF  = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // field widths of the stream payload
    localparam int FIELD_W      = 32;
    localparam int INDEX_W      = 6;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 7;

    // input tdata: entry_index, entry_x, entry_y, query_x, padded to bytes
    localparam int IN_DATA_W    = INDEX_W + 3 * FIELD_W;
    localparam int IN_TDATA_W   = ((IN_DATA_W + 7) / 8) * 8;
    localparam int IN_X_LSB     = INDEX_W;
    localparam int IN_Y_LSB     = INDEX_W + FIELD_W;
    localparam int IN_Q_LSB     = INDEX_W + 2 * FIELD_W;

    // output tdata: y_result, segment_end, status
    localparam int OUT_DATA_W   = FIELD_W + INDEX_W + STATUS_W;
    localparam int OUT_TDATA_W  = ((OUT_DATA_W + 7) / 8) * 8;

    // item kinds carried on s_tuser
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BELOW = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_ABOVE = 2'd3;

    // register map, selected by paddr[2]
    localparam logic REG_POINT_COUNT = 1'b0;

endpackage
`default_nettype wire

// ----- src/piecewise_linear_lookup_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_linear_lookup_core
// Breakpoint table with hinted segment search and exact linear interpolation.
// ----------------------------------------------------------------------------
// Write items (s_tuser low) store one (x, y) breakpoint.
// Query items (s_tuser high) return one result; the core holds s_tready low
// until the query is finished. An empty table is answered without a memory read.
// Otherwise the search reads the breakpoint memory once for each breakpoint
// it steps over from the remembered segment (or from slot 0); interpolation
// then runs the adder for VALUE_WIDTH+1 shift-add multiply steps and the
// subtractor for 2*VALUE_WIDTH+2 restoring divide steps. point_count must be
// set over the register port only while no query is in flight; the core
// itself does not enforce this.

module piecewise_linear_lookup_core #(
    parameter int MAX_POINTS  = pll_pkg::MAX_POINTS_DEF,
    parameter int VALUE_WIDTH = pll_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // entry_index[5:0], entry_x[37:6], entry_y[69:38], query_x[101:70], zero pad
    input  wire logic [pll_pkg::IN_TDATA_W-1:0]  s_tdata,
    // func[0]
    input  wire logic                            s_tuser,
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // y_result[31:0], segment_end[37:32], status[39:38]
    output logic [pll_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // register port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [2:0]                      paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    localparam int VW   = VALUE_WIDTH;
    localparam int AW   = $clog2(MAX_POINTS);
    localparam int XW   = (AW + 1 > pll_pkg::COUNT_W) ? AW + 1 : pll_pkg::COUNT_W;
    localparam int DW   = VW + 1;          // offsets and segment width
    localparam int NW   = 2 * VW + 2;      // numerator
    localparam int CNTW = $clog2(NW);
    localparam int FW   = pll_pkg::FIELD_W;
    localparam int OTW  = pll_pkg::OUT_TDATA_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WAIT, ST_FIRST, ST_HINT, ST_ISSUE, ST_WALK,
        ST_SEG, ST_MUL, ST_SIGN, ST_DIV, ST_FIN, ST_OUT
    } state_t;

    // field to value: low VALUE_WIDTH bits, zero above the field
    function automatic logic [VW-1:0] field_to_value(input logic [FW-1:0] f);
        logic [VW-1:0] v;
        for (int i = 0; i < VW; i++) begin
            v[i] = (i < FW) ? f[i] : 1'b0;
        end
        return v;
    endfunction

    // value to field: sign extended or truncated to the field width
    function automatic logic [FW-1:0] value_to_field(input logic [VW-1:0] v);
        logic [FW-1:0] f;
        for (int i = 0; i < FW; i++) begin
            f[i] = (i < VW) ? v[i] : v[VW-1];
        end
        return f;
    endfunction

    // register port
    logic [pll_pkg::COUNT_W-1:0] point_count_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= '0;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == pll_pkg::REG_POINT_COUNT) begin
            point_count_reg <= pwdata[pll_pkg::COUNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == pll_pkg::REG_POINT_COUNT) begin
            prdata = {{(32 - pll_pkg::COUNT_W){1'b0}}, point_count_reg};
        end
    end

    // input field split
    logic                           in_accept;
    logic [pll_pkg::INDEX_W-1:0]    in_index;
    logic [VW-1:0]                  in_x;
    logic [VW-1:0]                  in_y;
    logic [VW-1:0]                  in_q;
    logic [XW-1:0]                  slot_ext;
    logic                           slot_ok;

    assign in_accept = s_tvalid && s_tready;
    assign in_index  = s_tdata[pll_pkg::INDEX_W-1:0];
    assign in_x      = field_to_value(s_tdata[pll_pkg::IN_X_LSB +: FW]);
    assign in_y      = field_to_value(s_tdata[pll_pkg::IN_Y_LSB +: FW]);
    assign in_q      = field_to_value(s_tdata[pll_pkg::IN_Q_LSB +: FW]);
    assign slot_ext  = {{(XW - pll_pkg::INDEX_W){1'b0}}, in_index};
    assign slot_ok   = slot_ext < XW'(MAX_POINTS);

    // breakpoint memories, one write and one registered read per cycle
    logic [VW-1:0] x_mem [MAX_POINTS];
    logic [VW-1:0] y_mem [MAX_POINTS];
    logic [AW-1:0] rd_addr_reg;
    logic [VW-1:0] x_rd_reg;
    logic [VW-1:0] y_rd_reg;

    always_ff @(posedge aclk) begin
        if (in_accept && s_tuser == pll_pkg::FUNC_WRITE && slot_ok) begin
            x_mem[slot_ext[AW-1:0]] <= in_x;
            y_mem[slot_ext[AW-1:0]] <= in_y;
        end
        x_rd_reg <= x_mem[rd_addr_reg];
        y_rd_reg <= y_mem[rd_addr_reg];
    end

    // sequencer registers
    state_t                          state_reg;
    state_t                          ret_reg;
    logic [AW-1:0]                   hint_reg;
    logic [XW-1:0]                   n_reg;
    logic [VW-1:0]                   q_reg;
    logic [VW-1:0]                   x1_reg;
    logic [VW-1:0]                   y1_reg;
    logic [VW-1:0]                   y0_reg;
    logic [DW-1:0]                   a_reg;
    logic [DW-1:0]                   b_reg;
    logic [DW-1:0]                   den_reg;
    logic [NW-1:0]                   acc_reg;
    logic [NW-1:0]                   mag_reg;
    logic [DW-1:0]                   rem_reg;
    logic                            neg_reg;
    logic [CNTW-1:0]                 cnt_reg;
    logic [VW-1:0]                   res_reg;
    logic [AW-1:0]                   seg_reg;
    logic [pll_pkg::STATUS_W-1:0]    stat_reg;
    logic                            m_valid_reg;
    logic [VW-1:0]                   m_res_reg;
    logic [AW-1:0]                   m_seg_reg;
    logic [pll_pkg::STATUS_W-1:0]    m_stat_reg;

    // derived values for the sequencer
    logic [XW-1:0]   count_ext;
    logic [XW-1:0]   n_eff;
    logic [XW-1:0]   hint_ext;
    logic [XW-1:0]   hint_p1;
    logic [XW-1:0]   hint_p2;
    logic [DW-1:0]   diff_a;
    logic [DW-1:0]   diff_b;
    logic [DW-1:0]   diff_den;
    logic [NW-1:0]   term1;
    logic [NW-1:0]   term0;
    logic [NW-1:0]   acc_next;
    logic [DW:0]     rem_shift;
    logic            rem_ge;
    logic [DW:0]     rem_sub;
    logic [VW:0]     avg_sum;
    logic [VW:0]     avg_adj;
    logic [NW-1:0]   sat_lim;
    logic [NW-1:0]   sat_mag;
    logic [VW-1:0]   fin_res;
    logic            x_rd_above_q;
    logic            x_rd_below_q;

    always_comb begin
        count_ext = XW'(point_count_reg);
        n_eff     = (count_ext > XW'(MAX_POINTS)) ? XW'(MAX_POINTS) : count_ext;
        hint_ext  = {{(XW - AW){1'b0}}, hint_reg};
        hint_p1   = hint_ext + XW'(1);
        hint_p2   = hint_ext + XW'(2);

        x_rd_above_q = $signed(x_rd_reg) > $signed(q_reg);
        x_rd_below_q = $signed(x_rd_reg) < $signed(q_reg);

        // offsets within the segment, all nonnegative
        diff_a   = {q_reg[VW-1], q_reg} - {x_rd_reg[VW-1], x_rd_reg};
        diff_b   = {x1_reg[VW-1], x1_reg} - {q_reg[VW-1], q_reg};
        diff_den = {x1_reg[VW-1], x1_reg} - {x_rd_reg[VW-1], x_rd_reg};

        // shift-add step of a*y1 + b*y0, most significant bit first
        term1    = a_reg[DW-1] ? {{(NW - VW){y1_reg[VW-1]}}, y1_reg} : '0;
        term0    = b_reg[DW-1] ? {{(NW - VW){y0_reg[VW-1]}}, y0_reg} : '0;
        acc_next = {acc_reg[NW-2:0], 1'b0} + term1 + term0;

        // restoring divide step
        rem_shift = {rem_reg, mag_reg[NW-1]};
        rem_ge    = rem_shift >= {1'b0, den_reg};
        rem_sub   = rem_shift - {1'b0, den_reg};

        // zero-width segment: mean of the two ordinates, toward zero
        avg_sum = {y1_reg[VW-1], y1_reg} + {y_rd_reg[VW-1], y_rd_reg};
        avg_adj = avg_sum + {{VW{1'b0}}, avg_sum[VW]};

        // saturate the quotient magnitude and restore the sign
        sat_lim = neg_reg ? (NW'(1) << (VW - 1)) : ((NW'(1) << (VW - 1)) - NW'(1));
        sat_mag = (mag_reg > sat_lim) ? sat_lim : mag_reg;
        fin_res = neg_reg ? (~sat_mag[VW-1:0] + VW'(1)) : sat_mag[VW-1:0];
    end

    assign s_tready = (state_reg == ST_IDLE);

    // sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            hint_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // result taken and nothing new handed over
            if (m_tready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_accept && s_tuser == pll_pkg::FUNC_QUERY) begin
                        q_reg       <= in_q;
                        n_reg       <= n_eff;
                        rd_addr_reg <= '0;
                        seg_reg     <= '0;
                        if (n_eff == '0) begin
                            res_reg   <= {1'b0, {(VW - 1){1'b1}}};
                            stat_reg  <= pll_pkg::STATUS_EMPTY;
                            state_reg <= ST_OUT;
                        end else begin
                            ret_reg   <= ST_FIRST;
                            state_reg <= ST_WAIT;
                        end
                    end
                end
                // memory read latency
                ST_WAIT: begin
                    state_reg <= ret_reg;
                end
                // first breakpoint: single entry, below range, hint check
                ST_FIRST: begin
                    if (n_reg == XW'(1)) begin
                        res_reg   <= y_rd_reg;
                        stat_reg  <= pll_pkg::STATUS_OK;
                        state_reg <= ST_OUT;
                    end else if (x_rd_above_q) begin
                        res_reg   <= '0;
                        stat_reg  <= pll_pkg::STATUS_BELOW;
                        state_reg <= ST_OUT;
                    end else if (hint_ext >= n_reg || hint_reg == '0) begin
                        hint_reg  <= '0;
                        state_reg <= ST_ISSUE;
                    end else begin
                        rd_addr_reg <= hint_reg;
                        ret_reg     <= ST_HINT;
                        state_reg   <= ST_WAIT;
                    end
                end
                // restart from slot 0 when the hint is past the query
                ST_HINT: begin
                    if (x_rd_above_q) begin
                        hint_reg <= '0;
                    end
                    state_reg <= ST_ISSUE;
                end
                ST_ISSUE: begin
                    if (hint_p1 < n_reg) begin
                        rd_addr_reg <= hint_p1[AW-1:0];
                        ret_reg     <= ST_WALK;
                        state_reg   <= ST_WAIT;
                    end else begin
                        res_reg   <= '0;
                        stat_reg  <= pll_pkg::STATUS_ABOVE;
                        state_reg <= ST_OUT;
                    end
                end
                // x_rd is the breakpoint after the hint
                ST_WALK: begin
                    if (x_rd_below_q) begin
                        hint_reg <= hint_p1[AW-1:0];
                        if (hint_p2 < n_reg) begin
                            rd_addr_reg <= hint_p2[AW-1:0];
                            ret_reg     <= ST_WALK;
                            state_reg   <= ST_WAIT;
                        end else begin
                            res_reg   <= '0;
                            stat_reg  <= pll_pkg::STATUS_ABOVE;
                            state_reg <= ST_OUT;
                        end
                    end else begin
                        x1_reg      <= x_rd_reg;
                        y1_reg      <= y_rd_reg;
                        seg_reg     <= hint_p1[AW-1:0];
                        rd_addr_reg <= hint_reg;
                        ret_reg     <= ST_SEG;
                        state_reg   <= ST_WAIT;
                    end
                end
                // x_rd is the lower breakpoint of the segment
                ST_SEG: begin
                    stat_reg <= pll_pkg::STATUS_OK;
                    if (x_rd_reg == x1_reg) begin
                        res_reg   <= avg_adj[VW:1];
                        state_reg <= ST_OUT;
                    end else begin
                        y0_reg    <= y_rd_reg;
                        a_reg     <= diff_a;
                        b_reg     <= diff_b;
                        den_reg   <= diff_den;
                        acc_reg   <= '0;
                        cnt_reg   <= CNTW'(DW - 1);
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    acc_reg <= acc_next;
                    a_reg   <= {a_reg[DW-2:0], 1'b0};
                    b_reg   <= {b_reg[DW-2:0], 1'b0};
                    if (cnt_reg == '0) begin
                        state_reg <= ST_SIGN;
                    end else begin
                        cnt_reg <= cnt_reg - CNTW'(1);
                    end
                end
                ST_SIGN: begin
                    neg_reg   <= acc_reg[NW-1];
                    mag_reg   <= acc_reg[NW-1] ? (~acc_reg + NW'(1)) : acc_reg;
                    rem_reg   <= '0;
                    cnt_reg   <= CNTW'(NW - 1);
                    state_reg <= ST_DIV;
                end
                // quotient bits shift in as numerator bits shift out
                ST_DIV: begin
                    rem_reg <= rem_ge ? rem_sub[DW-1:0] : rem_shift[DW-1:0];
                    mag_reg <= {mag_reg[NW-2:0], rem_ge};
                    if (cnt_reg == '0) begin
                        state_reg <= ST_FIN;
                    end else begin
                        cnt_reg <= cnt_reg - CNTW'(1);
                    end
                end
                ST_FIN: begin
                    res_reg   <= fin_res;
                    state_reg <= ST_OUT;
                end
                // hand over once the output register is free
                ST_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_res_reg   <= res_reg;
                        m_seg_reg   <= seg_reg;
                        m_stat_reg  <= stat_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result packing
    logic [pll_pkg::INDEX_W-1:0] seg_field;

    always_comb begin
        for (int i = 0; i < pll_pkg::INDEX_W; i++) begin
            seg_field[i] = (i < AW) ? m_seg_reg[i] : 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OTW'({m_stat_reg, seg_field, value_to_field(m_res_reg)});

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for piecewise_linear_lookup_core. Breakpoints are loaded
// over the input stream and point_count over the register port. Each query is
// predicted with exact 128-bit interpolation and its hinted segment walk.
// Results are checked in order, field by field. Directed cases come first:
// empty table, full-range segment, one entry, zero-width segment, hint
// restart, count above the table size. Random phases follow, mostly sorted
// tables with in-range queries, plus unsorted tables and stray writes. Both
// stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     HALF_PERIOD  = 5;
    localparam int     TABLE_DEPTH  = pll_pkg::MAX_POINTS_DEF;
    localparam int     ITEM_TARGET  = 850;
    localparam int     DRAIN_CYCLES = 16;
    localparam int     END_CYCLES   = 400;
    localparam int     CYCLE_LIMIT  = 1_000_000;
    localparam longint VAL_MIN      = -64'sd2147483648;
    localparam longint VAL_MAX      = 64'sd2147483647;

    // packed from the top bit down: status, segment_end, y_result
    typedef struct packed {
        logic [pll_pkg::STATUS_W-1:0] status;
        logic [pll_pkg::INDEX_W-1:0]  segment_end;
        logic [pll_pkg::FIELD_W-1:0]  y_result;
    } lookup_result_t;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [pll_pkg::IN_TDATA_W-1:0]    s_tdata;
    logic                              s_tuser;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [pll_pkg::OUT_TDATA_W-1:0]   m_tdata;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [2:0]                        paddr;
    logic [31:0]                       pwdata;
    logic [31:0]                       prdata;
    logic                              pready;

    // shadow copy of the block state
    logic signed [pll_pkg::FIELD_W-1:0] bp_x [TABLE_DEPTH];
    logic signed [pll_pkg::FIELD_W-1:0] bp_y [TABLE_DEPTH];
    int                                 seg_hint;
    logic [pll_pkg::COUNT_W-1:0]        active_count;
    longint                             tbl_lo;
    longint                             tbl_hi;

    lookup_result_t pending_lookups [$];
    lookup_result_t want_result;
    lookup_result_t got_result;
    int             errors;
    int             items_sent;
    int             cycle_count;
    int             stall_left;
    bit             src_gaps_on;
    bit             sink_stalls_on;

    piecewise_linear_lookup_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    // expected answer of one query; updates the segment hint like the block
    function automatic lookup_result_t interpolate_lookup(
        logic signed [pll_pkg::FIELD_W-1:0] qx);
        lookup_result_t    res;
        int                n;
        int                upper;
        longint            q, x0, x1, y0, y1;
        logic signed [127:0] num, den, quo;
        res = '0;
        res.status = pll_pkg::STATUS_OK;
        n = (active_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_count);
        q = longint'(qx);
        if (n == 0) begin
            res.y_result = 32'h7FFF_FFFF;
            res.status   = pll_pkg::STATUS_EMPTY;
        end else if (n == 1) begin
            res.y_result = bp_y[0];
        end else if (bp_x[0] > qx) begin
            res.status = pll_pkg::STATUS_BELOW;
        end else begin
            // restart from slot 0 when the hint is stale or past the query
            if (seg_hint >= n || bp_x[seg_hint] > qx)
                seg_hint = 0;
            while (seg_hint + 1 < n && bp_x[seg_hint + 1] < qx)
                seg_hint++;
            if (seg_hint + 1 >= n) begin
                res.status = pll_pkg::STATUS_ABOVE;
            end else begin
                upper = seg_hint + 1;
                x0 = longint'(bp_x[upper - 1]);
                x1 = longint'(bp_x[upper]);
                y0 = longint'(bp_y[upper - 1]);
                y1 = longint'(bp_y[upper]);
                res.segment_end = upper[pll_pkg::INDEX_W-1:0];
                if (x1 == x0) begin
                    // zero-width segment: mean of both ordinates
                    res.y_result = 32'((y0 + y1) / 2);
                end else begin
                    num = 128'(q - x0) * 128'(y1) + 128'(x1 - q) * 128'(y0);
                    den = 128'(x1 - x0);
                    quo = num / den;
                    if (quo > 128'(VAL_MAX))
                        quo = 128'(VAL_MAX);
                    else if (quo < 128'(VAL_MIN))
                        quo = 128'(VAL_MIN);
                    res.y_result = quo[pll_pkg::FIELD_W-1:0];
                end
            end
        end
        return res;
    endfunction

    function automatic int pick_gap(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [pll_pkg::FIELD_W-1:0] rand_ordinate();
        if ($urandom_range(0, 1) == 1)
            return $urandom;
        return 32'($urandom_range(0, 4000)) - 32'sd2000;
    endfunction

    function automatic logic [pll_pkg::INDEX_W-1:0] rand_index();
        logic [31:0] r;
        r = $urandom;
        return r[pll_pkg::INDEX_W-1:0];
    endfunction

    // one input transfer, predicted when accepted
    task automatic send_item(input logic func,
                             input logic [pll_pkg::INDEX_W-1:0] idx,
                             input logic signed [pll_pkg::FIELD_W-1:0] ex,
                             input logic signed [pll_pkg::FIELD_W-1:0] ey,
                             input logic signed [pll_pkg::FIELD_W-1:0] qx);
        int                             gap;
        logic [pll_pkg::IN_TDATA_W-1:0] word;
        gap = pick_gap(src_gaps_on);
        word = '0;
        word[pll_pkg::INDEX_W-1:0]                  = idx;
        word[pll_pkg::IN_X_LSB +: pll_pkg::FIELD_W] = ex;
        word[pll_pkg::IN_Y_LSB +: pll_pkg::FIELD_W] = ey;
        word[pll_pkg::IN_Q_LSB +: pll_pkg::FIELD_W] = qx;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  = func;
        s_tdata  = word;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (func == pll_pkg::FUNC_WRITE) begin
            bp_x[idx] = ex;
            bp_y[idx] = ey;
        end else begin
            pending_lookups = {pending_lookups, interpolate_lookup(qx)};
        end
    endtask

    task automatic write_point(input logic [pll_pkg::INDEX_W-1:0] idx,
                               input logic signed [pll_pkg::FIELD_W-1:0] ex,
                               input logic signed [pll_pkg::FIELD_W-1:0] ey);
        send_item(pll_pkg::FUNC_WRITE, idx, ex, ey, $urandom);
    endtask

    task automatic lookup(input logic signed [pll_pkg::FIELD_W-1:0] qx);
        send_item(pll_pkg::FUNC_QUERY, rand_index(), $urandom, $urandom, qx);
    endtask

    // wait until every expected result is in and the block has settled
    task automatic drain_block();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // register write, then read back
    task automatic set_point_count(input logic [pll_pkg::COUNT_W-1:0] value);
        drain_block();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {pll_pkg::REG_POINT_COUNT, 2'b00};
        pwdata  = 32'(value);
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        active_count = value;
        @(negedge aclk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== 32'(value)) begin
            $display("%0t: point_count readback mismatch: expected %h actual %h",
                     $time, 32'(value), prdata);
            errors++;
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // fill slots 0..count-1, capped at the table depth, ascending with random steps or fully random
    task automatic load_table(input int count, input bit sorted);
        int     slots;
        longint span, step_max, x;
        slots = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
        case ($urandom_range(0, 3))
            0: span = 64'sd256;
            1: span = 64'sd65536;
            2: span = 64'sd16777216;
            default: span = 64'sd4294967295;
        endcase
        x = VAL_MIN + longint'($urandom) % (64'sd4294967296 - span);
        step_max = span / ((slots > 1) ? slots - 1 : 1);
        for (int i = 0; i < slots; i++) begin
            if (!sorted)
                x = longint'($signed($urandom));
            write_point(i[pll_pkg::INDEX_W-1:0], 32'(x), rand_ordinate());
            if (i == 0 || x < tbl_lo)
                tbl_lo = x;
            if (i == 0 || x > tbl_hi)
                tbl_hi = x;
            // some repeated abscissas give zero-width segments
            if ($urandom_range(0, 7) != 0)
                x += longint'($urandom) % (step_max + 1);
        end
    endtask

    function automatic logic signed [pll_pkg::FIELD_W-1:0] pick_query(int slots);
        int     r;
        longint q;
        r = $urandom_range(0, 99);
        q = longint'($signed($urandom));
        if (r < 65)
            q = tbl_lo + longint'($urandom) % (tbl_hi - tbl_lo + 1);
        else if (r < 78)
            q = longint'(bp_x[$urandom_range(0, slots - 1)]);
        else if (r < 86 && tbl_lo > VAL_MIN)
            q = VAL_MIN + longint'($urandom) % (tbl_lo - VAL_MIN);
        else if (r < 94 && tbl_hi < VAL_MAX)
            q = tbl_hi + 1 + longint'($urandom) % (VAL_MAX - tbl_hi);
        return 32'(q);
    endfunction

    // empty table answers with the maximum value
    task automatic test_empty_table();
        lookup(32'sh8000_0000);
        lookup(32'sh7FFF_FFFF);
    endtask

    // whole table written first, then one segment spanning the full range
    task automatic test_full_range_segment();
        load_table(TABLE_DEPTH, 1'b1);
        write_point(6'd0, 32'sh8000_0000, 32'sh8000_0000);
        write_point(6'd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        write_point(6'd63, 32'sh7FFF_FFFF, 32'sh0000_0000);
        set_point_count(7'd2);
        lookup(32'sh8000_0000);
        lookup(32'sh7FFF_FFFF);
        lookup(32'sh0000_0000);
        lookup(32'shFFFF_FFFF);
    endtask

    task automatic test_single_point();
        set_point_count(7'd1);
        lookup($urandom);
        lookup(32'sh8000_0000);
    endtask

    // mean of 3 and -8 truncates toward zero
    task automatic test_zero_width_segment();
        write_point(6'd0, 32'sh0005_0000, 32'sd3);
        write_point(6'd1, 32'sh0005_0000, -32'sd8);
        write_point(6'd2, 32'sh0064_0000, 32'sh0001_0000);
        set_point_count(7'd3);
        lookup(32'sh0005_0000);
        lookup(32'sh0032_0000);
    endtask

    // below and above the table, hint past query, count beyond the table
    task automatic test_hint_and_range();
        lookup(32'shFF00_0000);
        lookup(32'sh0100_0000);
        lookup(32'sh0032_0000);
        set_point_count(7'd127);
        lookup(32'sh7FFF_FFFF);
        set_point_count(7'd3);
        lookup(32'sh0006_0000);
    endtask

    // random phases: pick a count, maybe reload, then a run of queries
    task automatic test_random_tables();
        int n, r, slots, queries;
        while (items_sent < ITEM_TARGET) begin
            src_gaps_on    = ($urandom_range(0, 3) != 0);
            sink_stalls_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 5)
                n = 0;
            else if (r < 10)
                n = 1;
            else if (r < 75)
                n = $urandom_range(2, 12);
            else if (r < 90)
                n = $urandom_range(13, 40);
            else if (r < 96)
                n = TABLE_DEPTH;
            else
                n = $urandom_range(TABLE_DEPTH + 1, 127);
            slots = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
            if (n > 0 && (n <= TABLE_DEPTH || $urandom_range(0, 1) == 1))
                load_table(n, $urandom_range(0, 9) != 0);
            set_point_count(n[pll_pkg::COUNT_W-1:0]);
            queries = $urandom_range(8, 24);
            for (int i = 0; i < queries; i++) begin
                if ($urandom_range(0, 99) < 6)
                    write_point(rand_index(), $urandom, rand_ordinate());
                else if (slots < 2)
                    lookup($urandom);
                else
                    lookup(pick_query(slots));
            end
        end
    endtask

    // result sink stalls
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else if (sink_stalls_on && $urandom_range(0, 99) < 25) begin
            m_tready = 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(0, 2);
        end else begin
            m_tready = 1'b1;
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_result = m_tdata[pll_pkg::OUT_DATA_W-1:0];
            if (pending_lookups.size() == 0) begin
                $display("%0t: unexpected result: expected none actual %h",
                         $time, got_result);
                errors++;
            end else begin
                want_result = pending_lookups.pop_front();
                if (got_result.y_result !== want_result.y_result) begin
                    $display("%0t: y_result mismatch: expected %h actual %h",
                             $time, want_result.y_result, got_result.y_result);
                    errors++;
                end
                if (got_result.segment_end !== want_result.segment_end) begin
                    $display("%0t: segment_end mismatch: expected %0d actual %0d",
                             $time, want_result.segment_end, got_result.segment_end);
                    errors++;
                end
                if (got_result.status !== want_result.status) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want_result.status, got_result.status);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge aclk);
        $display("DONE: errors detected");
        $finish;
    end

    // test sequence
    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tuser        = pll_pkg::FUNC_WRITE;
        s_tdata        = '0;
        m_tready       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        errors         = 0;
        items_sent     = 0;
        cycle_count    = 0;
        stall_left     = 0;
        seg_hint       = 0;
        active_count   = '0;
        tbl_lo         = 0;
        tbl_hi         = 0;
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        test_empty_table();
        test_full_range_segment();
        test_single_point();
        test_zero_width_segment();
        test_hint_and_range();
        test_random_tables();

        drain_block();
        repeat (END_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire

// ----- files.f -----
src/pll_pkg.sv
src/piecewise_linear_lookup_core.sv
tb/tb_top.sv
